// File: rtl/core/obps_pkg.sv
package obps_pkg;

    localparam int DATA_W            = 8;
    localparam int ADDR_W            = 32;
    localparam int CNT_W             = 32;
    localparam int LEN_W             = 4;
    localparam int PATTERN_W         = 64;
    localparam int PATTERN_SLOTS     = PATTERN_W / DATA_W;
    localparam int PAT_IDX_W         = $clog2(PATTERN_SLOTS);
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int MAX_PATTERN_BYTES = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 8'd0,
        CFG_PATTERN_LENGTH = 8'd1,
        CFG_RANGE_BASE     = 8'd2,
        CFG_REPORT_LIMIT   = 8'd3
    } cfg_index_t;

    // per-cycle window control shared by every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] hit_start;
        logic              hit_recorded;
        logic              scan_done;
        logic [CNT_W-1:0]  hit_total;
    } result_t;

endpackage

// File: rtl/core/obps_in_if.sv
interface obps_in_if;

    logic                        valid;
    logic                        ready;
    logic [obps_pkg::DATA_W-1:0] data_byte;
    logic                        final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);

endinterface

// File: rtl/core/obps_out_if.sv
interface obps_out_if;

    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [obps_pkg::ADDR_W-1:0] hit_start;
    logic                        hit_recorded;
    logic                        scan_done;
    logic [obps_pkg::CNT_W-1:0]  hit_total;

    modport source (
        output valid, output hit, output hit_start, output hit_recorded,
        output scan_done, output hit_total, input ready
    );
    modport sink (
        input valid, input hit, input hit_start, input hit_recorded,
        input scan_done, input hit_total, output ready
    );

endinterface

// File: rtl/core/obps_cfg_if.sv
interface obps_cfg_if;

    logic                             valid;
    logic                             ready;
    logic [obps_pkg::CFG_INDEX_W-1:0] index;
    logic [obps_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// File: rtl/core/overlapping_byte_pattern_scan.sv
// channel   | dir | transaction payload
// data_ch   | in  | data_byte, final_byte
// result_ch | out | hit, hit_start, hit_recorded, scan_done, hit_total
// cfg_ch    | in  | index, data (0 pattern, 1 length, 2 base, 3 limit)
//
// one byte per cycle: the current byte and the MAX_PATTERN_BYTES-1 window
// cells are compared in parallel, and the result is registered at the edge
// that takes the byte, into the output register or, while a result waits
// there, into the skid entry. this two-deep output stage keeps bytes flowing
// until a second result fills the skid entry. reset clears the window, offset,
// hit count, valid flags and settings (length to 1); cfg_ch is always ready.
module overlapping_byte_pattern_scan
#(
    parameter int MAX_PATTERN_BYTES = obps_pkg::MAX_PATTERN_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    obps_in_if.sink     data_ch,
    obps_out_if.source  result_ch,
    obps_cfg_if.sink    cfg_ch
);

    localparam int DATA_W    = obps_pkg::DATA_W;
    localparam int ADDR_W    = obps_pkg::ADDR_W;
    localparam int CNT_W     = obps_pkg::CNT_W;
    localparam int LEN_W     = obps_pkg::LEN_W;
    localparam int PAT_IDX_W = obps_pkg::PAT_IDX_W;
    localparam int P         = MAX_PATTERN_BYTES;

    logic [obps_pkg::PATTERN_W-1:0] pattern_reg;
    logic [LEN_W-1:0]               length_reg;
    logic [ADDR_W-1:0]              base_reg;
    logic [CNT_W-1:0]               limit_reg;

    logic [ADDR_W-1:0]              offset_reg;
    logic [ADDR_W-1:0]              offset_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;

    obps_pkg::result_t              out_reg;
    obps_pkg::result_t              out_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    obps_pkg::result_t              skid_reg;
    obps_pkg::result_t              skid_next;
    logic                           skid_valid_reg;
    logic                           skid_valid_next;

    logic [DATA_W-1:0]              pos [P];
    logic [P-1:0][DATA_W-1:0]       want;
    logic [P-1:0]                   enable;
    logic [P-1:0]                   match;
    obps_pkg::cell_ctrl_t           ctrl;

    logic                           accept;
    logic                           len_ok;
    logic                           hit;
    logic                           produce;
    logic [ADDR_W-1:0]              len_minus_one;
    obps_pkg::result_t              result;
    logic                           take;

    // configuration registers
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            base_reg    <= '0;
            limit_reg   <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                obps_pkg::CFG_PATTERN_BYTES:  pattern_reg <= cfg_ch.data;
                obps_pkg::CFG_PATTERN_LENGTH: length_reg  <= cfg_ch.data[LEN_W-1:0];
                obps_pkg::CFG_RANGE_BASE:     base_reg    <= cfg_ch.data[ADDR_W-1:0];
                obps_pkg::CFG_REPORT_LIMIT:   limit_reg   <= cfg_ch.data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pattern slot facing each window position; position k holds the byte k back
    always_comb
    begin
        logic [LEN_W-1:0] slot;
        len_ok = (length_reg != '0) && (length_reg <= LEN_W'(P));
        for (int k = 0; k < P; k++)
        begin
            slot      = length_reg - LEN_W'(1) - LEN_W'(k);
            enable[k] = len_ok && (LEN_W'(k) < length_reg);
            want[k]   = pattern_reg[slot[PAT_IDX_W-1:0]*DATA_W +: DATA_W];
        end
    end

    assign accept = data_ch.valid && data_ch.ready;
    assign ctrl.shift = accept && !data_ch.final_byte;
    assign ctrl.clear = accept && data_ch.final_byte;

    assign pos[0]   = data_ch.data_byte;
    assign match[0] = !enable[0] || (data_ch.data_byte == want[0]);

    for (genvar k = 1; k < P; k++)
    begin : g_cell
        obps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (pos[k-1]),
            .want     (want[k]),
            .enable   (enable[k]),
            .byte_out (pos[k]),
            .match    (match[k])
        );
    end

    assign len_minus_one = ADDR_W'(length_reg) - ADDR_W'(1);
    // no match may reach back before the first byte of the range
    assign hit     = len_ok && (&match) && (offset_reg >= len_minus_one);
    assign produce = hit || data_ch.final_byte;

    always_comb
    begin
        result              = '0;
        result.hit          = hit;
        result.scan_done    = data_ch.final_byte;
        result.hit_total    = count_reg;
        if (hit)
        begin
            result.hit_start    = base_reg + offset_reg - len_minus_one;
            result.hit_recorded = count_reg < limit_reg;
            if (count_reg != '1)
            begin
                result.hit_total = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        offset_next = offset_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (data_ch.final_byte)
            begin
                offset_next = '0;
                count_next  = '0;
            end
            else
            begin
                count_next = result.hit_total;
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + ADDR_W'(1);
                end
            end
        end
    end

    // output register with a skid entry behind it
    assign take          = out_valid_reg && result_ch.ready;
    assign data_ch.ready = !skid_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept && produce)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept && produce)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg     <= offset_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.hit          = out_reg.hit;
    assign result_ch.hit_start    = out_reg.hit_start;
    assign result_ch.hit_recorded = out_reg.hit_recorded;
    assign result_ch.scan_done    = out_reg.scan_done;
    assign result_ch.hit_total    = out_reg.hit_total;

endmodule

// File: rtl/core/obps_cell.sv
module obps_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  obps_pkg::cell_ctrl_t        ctrl,
    input  logic [obps_pkg::DATA_W-1:0] byte_in,
    input  logic [obps_pkg::DATA_W-1:0] want,
    input  logic                        enable,
    output logic [obps_pkg::DATA_W-1:0] byte_out,
    output logic                        match
);

    logic [obps_pkg::DATA_W-1:0] window_reg;
    logic [obps_pkg::DATA_W-1:0] window_next;

    always_comb
    begin
        window_next = window_reg;
        if (ctrl.clear)
        begin
            window_next = '0;
        end
        else if (ctrl.shift)
        begin
            window_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    assign byte_out = window_reg;
    // a slot beyond the pattern length always agrees
    assign match    = !enable || (window_reg == want);

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RANDOM_BYTES = 1030;
    localparam int          MAX_BYTES = obps_pkg::MAX_PATTERN_BYTES;

    typedef struct packed {
        logic [obps_pkg::DATA_W-1:0] data_byte;
        logic                        final_byte;
    } scan_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    obps_in_if  data_ch ();
    obps_out_if result_ch ();
    obps_cfg_if cfg_ch ();

    overlapping_byte_pattern_scan dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // register copies, as the block should hold them
    logic [obps_pkg::PATTERN_W-1:0] pattern_reg;
    logic [obps_pkg::LEN_W-1:0]     length_reg;
    logic [obps_pkg::ADDR_W-1:0]    base_reg;
    logic [obps_pkg::CNT_W-1:0]     limit_reg;

    // scan state: window entry 0 is the most recent byte
    logic [obps_pkg::DATA_W-1:0] window_bytes [0:MAX_BYTES-2];
    logic [obps_pkg::CNT_W-1:0]  scan_offset;
    logic [obps_pkg::CNT_W-1:0]  hits_in_scan;

    scan_byte_t          byte_queue [$];
    obps_pkg::result_t   awaited_results [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    bit          byte_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [15:0] ready_pattern = '0;
    int unsigned ready_bits_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // works out the result of one byte and advances the scan
    function automatic void scan_byte(input logic [obps_pkg::DATA_W-1:0] current,
                                      input logic last);
        obps_pkg::result_t           res;
        logic                        matched;
        logic [obps_pkg::DATA_W-1:0] seen;
        int unsigned                 back;
        int unsigned                 plen;
        plen = 32'(length_reg);
        res = '0;
        if (plen == 0 || plen > MAX_BYTES)
            matched = 1'b0;
        else if (scan_offset < plen - 1)
            matched = 1'b0;
        else
        begin
            matched = 1'b1;
            for (int i = 0; i < plen; i++)
            begin
                back = plen - 1 - i;
                seen = (back == 0) ? current : window_bytes[back-1];
                if (seen != pattern_reg[8*i +: 8])
                    matched = 1'b0;
            end
        end
        if (matched)
        begin
            res.hit = 1'b1;
            res.hit_start = base_reg + scan_offset - (plen - 1);
            res.hit_recorded = hits_in_scan < limit_reg;
            if (hits_in_scan != '1)
                hits_in_scan++;
        end
        if (matched || last)
        begin
            res.scan_done = last;
            res.hit_total = hits_in_scan;
            awaited_results.push_back(res);
        end
        if (last)
        begin
            for (int i = 0; i < MAX_BYTES - 1; i++)
                window_bytes[i] = '0;
            scan_offset = '0;
            hits_in_scan = '0;
        end
        else
        begin
            for (int i = MAX_BYTES - 2; i > 0; i--)
                window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = current;
            if (scan_offset != '1)
                scan_offset++;
        end
    endfunction

    task automatic check_result();
        obps_pkg::result_t got;
        obps_pkg::result_t want;
        got.hit = result_ch.hit;
        got.hit_start = result_ch.hit_start;
        got.hit_recorded = result_ch.hit_recorded;
        got.scan_done = result_ch.scan_done;
        got.hit_total = result_ch.hit_total;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with none awaited, hit_total", got.hit_total, '0);
            return;
        end
        want = awaited_results.pop_front();
        if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_start !== want.hit_start)
            report_mismatch("hit_start", got.hit_start, want.hit_start);
        if (got.hit_recorded !== want.hit_recorded)
            report_mismatch("hit_recorded", 32'(got.hit_recorded), 32'(want.hit_recorded));
        if (got.scan_done !== want.scan_done)
            report_mismatch("scan_done", 32'(got.scan_done), 32'(want.scan_done));
        if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", got.hit_total, want.hit_total);
    endtask

    // monitor: transactions are taken at the rising edge
    always @(posedge clk)
    begin
        byte_taken = rst_n && data_ch.valid && data_ch.ready;
        if (byte_taken)
            scan_byte(data_ch.data_byte, data_ch.final_byte);
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    // driver: bursts of bytes with random gaps, some bursts back to back
    always @(negedge clk)
    begin
        scan_byte_t item;
        if (rst_n)
        begin
            if (data_ch.valid && !byte_taken)
            begin
                // hold the transaction until it is taken
            end
            else if (gap_left != 0)
            begin
                data_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (byte_queue.size() != 0)
            begin
                item = byte_queue.pop_front();
                data_ch.valid <= 1'b1;
                data_ch.data_byte <= item.data_byte;
                data_ch.final_byte <= item.final_byte;
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                data_ch.valid <= 1'b0;
        end
    end

    // receiver stalls on a random 16-bit pattern, sometimes none at all
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_bits_left == 0)
            begin
                ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                ready_bits_left = 16;
            end
            result_ch.ready <= ready_pattern[0];
            ready_pattern = ready_pattern >> 1;
            ready_bits_left--;
        end
    end

    always @(posedge clk)
    begin
        if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("overlapping_byte_pattern_scan: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input obps_pkg::cfg_index_t idx,
                             input logic [obps_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            obps_pkg::CFG_PATTERN_BYTES:  pattern_reg = value;
            obps_pkg::CFG_PATTERN_LENGTH: length_reg = value[obps_pkg::LEN_W-1:0];
            obps_pkg::CFG_RANGE_BASE:     base_reg = value[obps_pkg::ADDR_W-1:0];
            obps_pkg::CFG_REPORT_LIMIT:   limit_reg = value[obps_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void push_byte(input logic [obps_pkg::DATA_W-1:0] b, input logic last);
        byte_queue.push_back(scan_byte_t'{data_byte: b, final_byte: last});
    endfunction

    // a result may still be in the output stage after the last awaited one
    task automatic wait_idle();
        while (byte_queue.size() != 0 || data_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_config();
        logic [7:0]                     b0;
        logic [7:0]                     b1;
        logic [obps_pkg::PATTERN_W-1:0] pat;
        logic [obps_pkg::LEN_W-1:0]     len;
        logic [obps_pkg::ADDR_W-1:0]    base;
        logic [obps_pkg::CNT_W-1:0]     lim;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        case ($urandom_range(0, 3))
            0: pat = {8{b0}};
            1: pat = {4{b1, b0}};
            default: pat = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 9))
            0: len = 4'd1;
            1: len = 4'd8;
            2: len = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            default: len = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 4))
            0: base = '0;
            1: base = '1;
            2: base = 32'hffff_ffff - $urandom_range(0, 40);
            default: base = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: lim = '0;
            1: lim = '1;
            default: lim = $urandom_range(0, 6);
        endcase
        write_reg(obps_pkg::CFG_PATTERN_BYTES, pat);
        write_reg(obps_pkg::CFG_PATTERN_LENGTH, 64'(len));
        write_reg(obps_pkg::CFG_RANGE_BASE, 64'(base));
        write_reg(obps_pkg::CFG_REPORT_LIMIT, 64'(lim));
        end_writes();
    endtask

    // mostly whole or spoilt occurrences of the pattern, some loose pattern bytes and noise
    task automatic queue_range(input int unsigned n, input bit close);
        int unsigned placed;
        int unsigned plen;
        int unsigned spoil;
        logic [7:0]  b;
        placed = 0;
        plen = (length_reg >= 1 && length_reg <= MAX_BYTES) ? 32'(length_reg)
                                                            : $urandom_range(1, 8);
        while (placed < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : plen;
                    for (int k = 0; k < plen && placed < n; k++)
                    begin
                        b = pattern_reg[8*k +: 8];
                        if (k == spoil)
                            b = b ^ (8'd1 << $urandom_range(0, 7));
                        push_byte(b, close && placed == n - 1);
                        placed++;
                    end
                end
                4, 5, 6, 7:
                begin
                    push_byte(pattern_reg[8*$urandom_range(0, plen - 1) +: 8],
                              close && placed == n - 1);
                    placed++;
                end
                default:
                begin
                    push_byte(8'($urandom), close && placed == n - 1);
                    placed++;
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned random_bytes;
        int unsigned ranges;
        int unsigned n;
        data_ch.valid = 1'b0;
        data_ch.data_byte = '0;
        data_ch.final_byte = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = obps_pkg::CFG_PATTERN_BYTES;
        cfg_ch.data = '0;
        pattern_reg = '0;
        length_reg = 4'd1;
        base_reg = '0;
        limit_reg = '0;
        for (int i = 0; i < MAX_BYTES - 1; i++)
            window_bytes[i] = '0;
        scan_offset = '0;
        hits_in_scan = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one zero byte pattern, nothing recorded
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h55, 1'b1);
        wait_idle();

        // longest pattern, overlapping runs, start addresses just below the top
        write_reg(obps_pkg::CFG_PATTERN_BYTES, '1);
        write_reg(obps_pkg::CFG_PATTERN_LENGTH, 64'd8);
        write_reg(obps_pkg::CFG_RANGE_BASE, 64'hffff_fffc);
        write_reg(obps_pkg::CFG_REPORT_LIMIT, 64'd1);
        end_writes();
        for (int i = 0; i < 9; i++)
            push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        wait_idle();

        // zero length and lengths past the maximum never match
        write_reg(obps_pkg::CFG_PATTERN_BYTES, '0);
        write_reg(obps_pkg::CFG_PATTERN_LENGTH, 64'd0);
        end_writes();
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();
        write_reg(obps_pkg::CFG_PATTERN_LENGTH, 64'd15);
        end_writes();
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // two-byte pattern over a run of three, all hits recorded
        write_reg(obps_pkg::CFG_PATTERN_BYTES, 64'haaaa);
        write_reg(obps_pkg::CFG_PATTERN_LENGTH, 64'd2);
        write_reg(obps_pkg::CFG_RANGE_BASE, 64'd0);
        write_reg(obps_pkg::CFG_REPORT_LIMIT, 64'hffff_ffff);
        end_writes();
        push_byte(8'haa, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'haa, 1'b1);
        wait_idle();

        // random part; a phase may leave its range open so the next settings apply mid scan
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            random_config();
            ranges = $urandom_range(1, 4);
            for (int r = 0; r < ranges; r++)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 30);
                queue_range(n, (r != ranges - 1) || ($urandom_range(0, 3) != 0));
                random_bytes += n;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("overlapping_byte_pattern_scan: match");
        else
            $display("overlapping_byte_pattern_scan: mismatch");
        $finish;
    end

endmodule
